@@ hw/rtl/max_gap_seat_allocator_defines.svh @@
// Assertion macros shared by the seat allocator RTL.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef MAX_GAP_SEAT_ALLOCATOR_DEFINES_SVH
`define MAX_GAP_SEAT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MGSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("seat allocator: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MGSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("seat allocator: next-cycle check failed");

`endif

@@ hw/rtl/mgsa_pkg.sv @@
// Shared types and constants of the max-gap seat allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mgsa_pkg;

    // Number of slot cells and the widths that follow from it.
    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    typedef enum logic {
        OP_SEAT  = 1'b0,
        OP_LEAVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STAT_SEATED    = 2'd0,
        STAT_FREED     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_BAD_LEAVE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } fsm_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] leave_slot;
    } in_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } out_res_t;

    // Controls of one occupancy cell.
    typedef struct packed {
        logic shift;
        logic set;
        logic clr;
    } cell_ctrl_t;

    // Controls of the gap evaluator.
    typedef struct packed {
        logic              clear;
        logic              step;
        logic [SLOT_W-1:0] idx;
        logic              occ_bit;
    } scan_ctrl_t;

    // Final decision of the gap evaluator.
    typedef struct packed {
        logic              full;
        logic [SLOT_W-1:0] pick;
    } scan_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/mgsa_cell.sv @@
// One occupancy cell of the rotating slot ring.
// Depends on mgsa_pkg for the cell control struct.
`default_nettype none

module mgsa_cell
    import mgsa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       next_in,
    output logic            occ
);

    logic occ_reg;
    logic occ_next;

    // Rotation takes the neighbor's bit; otherwise a seat sets and a leave clears.
    always_comb
    begin
        occ_next = occ_reg;
        if (ctrl.shift)
        begin
            occ_next = next_in;
        end
        else if (ctrl.set)
        begin
            occ_next = 1'b1;
        end
        else if (ctrl.clr)
        begin
            occ_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign occ = occ_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mgsa_scan.sv @@
// Gap evaluator: watches one occupancy bit per cycle at the ring's head
// and tracks the widest gap. Depends on mgsa_pkg.
`default_nettype none

module mgsa_scan
    import mgsa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire scan_ctrl_t       ctrl,
    input  wire logic [CNT_W-1:0] size,
    output scan_res_t             res
);

    logic              any_reg,   any_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] best_reg,  best_next;
    logic [SLOT_W-1:0] pick_reg,  pick_next;
    logic [SLOT_W-1:0] last_reg,  last_next;

    logic              in_room;
    logic [SLOT_W-1:0] half;
    logic [CNT_W-1:0]  tail;

    // Per-slot update: first occupied slot seeds the edge gap, later ones
    // offer the middle of the gap to their occupied neighbor.
    always_comb
    begin
        in_room    = {1'b0, ctrl.idx} < size;
        half       = (ctrl.idx - last_reg) >> 1;
        any_next   = any_reg;
        count_next = count_reg;
        best_next  = best_reg;
        pick_next  = pick_reg;
        last_next  = last_reg;
        if (ctrl.clear)
        begin
            any_next   = 1'b0;
            count_next = '0;
            best_next  = '0;
            pick_next  = '0;
            last_next  = '0;
        end
        else if (ctrl.step && in_room && ctrl.occ_bit)
        begin
            count_next = count_reg + CNT_W'(1);
            last_next  = ctrl.idx;
            if (!any_reg)
            begin
                any_next  = 1'b1;
                best_next = ctrl.idx;
                pick_next = '0;
            end
            else if (half > best_reg)
            begin
                best_next = half;
                pick_next = last_reg + half;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg   <= 1'b0;
            count_reg <= '0;
            best_reg  <= '0;
            pick_reg  <= '0;
            last_reg  <= '0;
        end
        else
        begin
            any_reg   <= any_next;
            count_reg <= count_next;
            best_reg  <= best_next;
            pick_reg  <= pick_next;
            last_reg  <= last_next;
        end
    end

    // Final decision: room full, or the far end beats the best gap.
    always_comb
    begin
        tail     = size - CNT_W'(1) - {1'b0, last_reg};
        res.full = (count_reg == size);
        res.pick = pick_reg;
        if (any_reg && (tail > {1'b0, best_reg}))
        begin
            res.pick = SLOT_W'(size - CNT_W'(1));
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/max_gap_seat_allocator.sv @@
// Max-gap seat allocator, top level.
// Request channel: in_valid/in_stall with in_data (op, leave_slot).
// Result channel: out_valid/out_stall with out_data (slot, status); one
// result per request, in request order.
// Configuration: cfg_valid/cfg_ready write channel for room_size; cfg_ready
// is always high. The user makes writes only while the block is idle; the
// block itself does not enforce this. Occupancy lives in a ring of one-bit
// cells. A seat request rotates the ring once through all MAX_SLOTS cells,
// one slot per cycle past the gap evaluator, then decides and sets the
// chosen cell; no new request is taken until its result is loaded. A leave
// request clears its cell in the accept cycle; its result is valid on the
// next cycle, and leaves can follow one per cycle while the output is not
// stalled.
// While a result waits under stall no request is taken; a seat already in
// the ring holds its result in the decide step until the output register frees.
// Reset empties the room, sets room_size to MAX_SLOTS and drops any result.
// Depends on mgsa_pkg, mgsa_cell, mgsa_scan and the assertion macro header.
`default_nettype none
`include "max_gap_seat_allocator_defines.svh"

module max_gap_seat_allocator
    import mgsa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_req_t          in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_res_t              out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CNT_W-1:0] cfg_data
);

    fsm_t              state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg,   idx_next;
    logic [CNT_W-1:0]  room_size_reg;
    logic              out_valid_reg, out_valid_next;
    out_res_t          out_data_reg,  out_data_next;

    logic [CNT_W-1:0]     eff_size;
    logic                 accept;
    logic                 out_busy;
    logic                 res_load;
    logic                 set_en;
    logic                 clr_en;
    logic                 shift_en;
    logic [MAX_SLOTS-1:0] occ;
    logic [MAX_SLOTS-1:0] leave_hit;
    logic                 leave_ok;
    cell_ctrl_t           cell_ctrl [MAX_SLOTS];
    scan_ctrl_t           scan_ctrl;
    scan_res_t            scan_res;

    // Room size clamped to 1..MAX_SLOTS.
    always_comb
    begin
        eff_size = room_size_reg;
        if (room_size_reg == '0)
        begin
            eff_size = CNT_W'(1);
        end
        else if (room_size_reg > CNT_W'(MAX_SLOTS))
        begin
            eff_size = CNT_W'(MAX_SLOTS);
        end
    end

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_size_reg <= CNT_W'(MAX_SLOTS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            room_size_reg <= cfg_data;
        end
    end

    // Handshake terms.
    assign out_busy = out_valid_reg && out_stall;
    assign in_stall = (state_reg != S_IDLE) || out_busy;
    assign accept   = in_valid && !in_stall;

    // A leave is valid when the addressed cell lies in the room and is occupied.
    always_comb
    begin
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            leave_hit[k] = (in_data.leave_slot == SLOT_W'(k)) && occ[k];
        end
        leave_ok = (|leave_hit) && ({1'b0, in_data.leave_slot} < eff_size);
    end

    // Sequencer: leaves complete in idle; a seat rotates the ring once, then decides and writes back.
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        res_load      = 1'b0;
        out_data_next = out_data_reg;
        set_en        = 1'b0;
        clr_en        = 1'b0;
        shift_en      = 1'b0;
        scan_ctrl     = '{clear: 1'b0, step: 1'b0, idx: idx_reg, occ_bit: occ[0]};
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.op == OP_LEAVE)
                    begin
                        res_load           = 1'b1;
                        clr_en             = leave_ok;
                        out_data_next.slot = in_data.leave_slot;
                        out_data_next.status = leave_ok ? STAT_FREED : STAT_BAD_LEAVE;
                    end
                    else
                    begin
                        scan_ctrl.clear = 1'b1;
                        idx_next        = '0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                scan_ctrl.step = 1'b1;
                shift_en       = 1'b1;
                idx_next       = idx_reg + SLOT_W'(1);
                if (idx_reg == SLOT_W'(MAX_SLOTS - 1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!out_busy)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    if (scan_res.full)
                    begin
                        out_data_next.slot   = '0;
                        out_data_next.status = STAT_FULL;
                    end
                    else
                    begin
                        set_en               = 1'b1;
                        out_data_next.slot   = scan_res.pick;
                        out_data_next.status = STAT_SEATED;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Per-cell controls: common rotate, decoded set and clear.
    always_comb
    begin
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            cell_ctrl[k].shift = shift_en;
            cell_ctrl[k].set   = set_en && (scan_res.pick == SLOT_W'(k));
            cell_ctrl[k].clr   = clr_en && (in_data.leave_slot == SLOT_W'(k));
        end
    end

    // Ring of cells; each cell takes its upper neighbor's bit on a rotate.
    for (genvar g = 0; g < MAX_SLOTS; g++)
    begin : g_cell
        mgsa_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl[g]),
            .next_in (occ[(g + 1) % MAX_SLOTS]),
            .occ     (occ[g])
        );
    end

    // Gap evaluator at the head of the ring.
    mgsa_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (scan_ctrl),
        .size  (eff_size),
        .res   (scan_res)
    );

    // Requests are only taken in the idle state.
    `MGSA_ASSERT_IMP(a_accept_idle, clk, rst_n, accept, state_reg == S_IDLE)
    // The ring is back in its home alignment when the decision is made.
    `MGSA_ASSERT_IMP(a_ring_home, clk, rst_n, state_reg == S_DECIDE, idx_reg == '0)
    // A seated slot is occupied right after the result is loaded.
    `MGSA_ASSERT_NXT(a_seat_marked, clk, rst_n,
        res_load && (out_data_next.status == STAT_SEATED),
        occ[out_data_reg.slot])
    // A seated slot lies inside the room.
    `MGSA_ASSERT_NXT(a_seat_in_room, clk, rst_n,
        res_load && (out_data_next.status == STAT_SEATED),
        ({1'b0, out_data_reg.slot} < eff_size))

endmodule

`default_nettype wire
